### rtl/rdv_pkg.sv
`timescale 1ns / 1ps
// rdv_pkg: shared types and constants for the root pointer descriptor validator
// used by rdv_core and rsdp_descriptor_validator_unit, no dependencies
package rdv_pkg;

  // default upper bound on the declared descriptor length
  localparam int unsigned RDV_MAX_BYTES_DEFAULT = 64;

  localparam int unsigned LEN_W      = 32;
  localparam int unsigned SIG_LEN    = 8;
  localparam int unsigned REV_OFFSET = 15;
  localparam int unsigned V1_LAST    = 19;
  localparam int unsigned LEN_FIRST  = 20;
  localparam int unsigned LEN_LAST   = 23;
  localparam int unsigned V2_LEN     = 36;
  localparam logic [7:0]  EXT_REVISION = 8'd2;

  // "RSD PTR "
  localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
    8'h52, 8'h53, 8'h44, 8'h20, 8'h50, 8'h54, 8'h52, 8'h20
  };

  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_SIGNATURE = 3'd1,
    REASON_CHECKSUM  = 3'd2,
    REASON_LEN_SHORT = 3'd3,
    REASON_EXT_CSUM  = 3'd4,
    REASON_LEN_OVER  = 3'd5
  } reason_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } byte_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] reason;
    logic [7:0] revision;
  } verdict_item_t;

endpackage

### rtl/rsdp_descriptor_validator_unit.sv
`timescale 1ns / 1ps
// rsdp_descriptor_validator_unit: top level, input register, core and verdict register
// depends on rdv_pkg and rdv_core
//
// Checks ACPI root pointer descriptors streamed one byte per transfer, with
// start_req on the first byte of each candidate. Each byte passes through a
// single update of the running sum and offset between the input register
// and the verdict register, so a byte is accepted every cycle while the
// verdict register is not stalled. At most one verdict leaves per
// candidate; bytes after it are dropped until the next start, and a start
// in mid candidate abandons the old one silently. Declared lengths above
// MAX_DESCRIPTOR_BYTES are reported as over limit without the extended sum.
module rsdp_descriptor_validator_unit #(
  parameter int unsigned MAX_DESCRIPTOR_BYTES = rdv_pkg::RDV_MAX_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  rdv_pkg::byte_item_t    byte_item,
  output logic                   verdict_valid,
  input  logic                   verdict_stall,
  output rdv_pkg::verdict_item_t verdict_item
);
  import rdv_pkg::*;

  logic          in_full;
  byte_item_t    in_q;
  logic          advance;
  logic          take;
  logic          res_valid;
  verdict_item_t res;

  assign advance    = !verdict_valid || !verdict_stall;
  assign take       = in_full && advance;
  assign byte_stall = in_full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      in_q <= byte_item;
    end
  end

  rdv_core #(
    .MAX_DESCRIPTOR_BYTES(MAX_DESCRIPTOR_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .item_take (take),
    .item      (in_q),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance) begin
      verdict_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      verdict_item <= res;
    end
  end

endmodule

### rtl/rdv_core.sv
`timescale 1ns / 1ps
// rdv_core: per-candidate state and the single-byte update of the validator
// depends on rdv_pkg
module rdv_core #(
  parameter int unsigned MAX_DESCRIPTOR_BYTES = rdv_pkg::RDV_MAX_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_take,
  input  rdv_pkg::byte_item_t    item,
  output logic                   res_valid,
  output rdv_pkg::verdict_item_t res
);
  import rdv_pkg::*;

  localparam int unsigned OFF_W = $clog2(MAX_DESCRIPTOR_BYTES + 1);

  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [7:0]       revision_seen, revision_seen_next;
  logic [LEN_W-1:0] declared_length, declared_length_next;
  logic             verdict_given;

  logic             active;
  logic [OFF_W-1:0] off_c;
  logic [7:0]       sum_c, rev_c;
  logic [LEN_W-1:0] len_c;
  logic             emit;
  logic             ok;
  reason_t          why;

  assign active = item.start_req || !verdict_given;

  always_comb begin
    // a start opens a fresh candidate at offset zero
    off_c = item.start_req ? '0 : byte_offset;
    sum_c = item.start_req ? '0 : running_sum;
    rev_c = item.start_req ? '0 : revision_seen;
    len_c = item.start_req ? '0 : declared_length;

    running_sum_next     = sum_c + item.data_byte;
    byte_offset_next     = off_c + OFF_W'(1);
    revision_seen_next   = rev_c;
    declared_length_next = len_c;
    emit = 1'b0;
    ok   = 1'b0;
    why  = REASON_OK;

    if (off_c < OFF_W'(SIG_LEN)) begin
      if (item.data_byte != SIG_BYTES[off_c[2:0]]) begin
        emit = 1'b1;
        why  = REASON_SIGNATURE;
      end
    end else begin
      if (off_c == OFF_W'(REV_OFFSET)) begin
        revision_seen_next = item.data_byte;
      end
      if (off_c == OFF_W'(V1_LAST)) begin
        if (running_sum_next != 8'd0) begin
          emit = 1'b1;
          why  = REASON_CHECKSUM;
        end else if (revision_seen_next < EXT_REVISION) begin
          emit = 1'b1;
          ok   = 1'b1;
        end
      end else if (off_c >= OFF_W'(LEN_FIRST) && off_c <= OFF_W'(LEN_LAST)) begin
        // little-endian length, bytes 20..23
        unique case (off_c[1:0])
          2'd0: declared_length_next[7:0]   = item.data_byte;
          2'd1: declared_length_next[15:8]  = item.data_byte;
          2'd2: declared_length_next[23:16] = item.data_byte;
          default: declared_length_next[31:24] = item.data_byte;
        endcase
        if (off_c == OFF_W'(LEN_LAST)) begin
          if (declared_length_next < LEN_W'(V2_LEN)) begin
            emit = 1'b1;
            why  = REASON_LEN_SHORT;
          end else if (declared_length_next > LEN_W'(MAX_DESCRIPTOR_BYTES)) begin
            emit = 1'b1;
            why  = REASON_LEN_OVER;
          end
        end
      end else if (off_c > OFF_W'(LEN_LAST) &&
                   (LEN_W'(off_c) + LEN_W'(1)) == len_c) begin
        emit = 1'b1;
        if (running_sum_next != 8'd0) begin
          why = REASON_EXT_CSUM;
        end else begin
          ok = 1'b1;
        end
      end
    end
  end

  assign res_valid     = item_take && active && emit;
  assign res.valid_res = ok;
  assign res.reason    = why;
  assign res.revision  = revision_seen_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset     <= '0;
      running_sum     <= '0;
      revision_seen   <= '0;
      declared_length <= '0;
      verdict_given   <= 1'b1;
    end else if (item_take && active) begin
      byte_offset     <= byte_offset_next;
      running_sum     <= running_sum_next;
      revision_seen   <= revision_seen_next;
      declared_length <= declared_length_next;
      verdict_given   <= emit;
    end
  end

endmodule

### test/rdv_verdict_checker.sv
`timescale 1ns / 1ps
// rdv_verdict_checker: watches both channels of the descriptor validator, predicts
// each verdict from the accepted bytes and compares it with what leaves the block
// depends on rdv_pkg
module rdv_verdict_checker #(
  parameter int unsigned MAX_BYTES = rdv_pkg::RDV_MAX_BYTES_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  input  logic                   byte_stall,
  input  rdv_pkg::byte_item_t    byte_item,
  input  logic                   verdict_valid,
  input  logic                   verdict_stall,
  input  rdv_pkg::verdict_item_t verdict_item,
  output int                     fail_count,
  output int                     outstanding,
  output int                     bytes_used,
  output int                     verdicts_due,
  output logic [5:0]             reasons_seen
);
  import rdv_pkg::*;

  // predictor copy of the candidate state
  int unsigned   next_offset;
  logic [7:0]    byte_sum;
  logic          sig_ok;
  logic [7:0]    rev_byte;
  logic [31:0]   decl_len;
  logic          in_candidate;

  verdict_item_t verdict_q[$];

  initial begin
    fail_count   = 0;
    bytes_used   = 0;
    verdicts_due = 0;
    reasons_seen = '0;
    outstanding  = 0;
  end

  function automatic void open_candidate(input logic live);
    next_offset  = 0;
    byte_sum     = 8'd0;
    sig_ok       = 1'b1;
    rev_byte     = 8'd0;
    decl_len     = 32'd0;
    in_candidate = live;
  endfunction

  function automatic void post_verdict(input logic ok, input reason_t why);
    verdict_item_t v;
    v.valid_res = ok;
    v.reason    = why;
    v.revision  = rev_byte;
    verdict_q.push_back(v);
    verdicts_due++;
    reasons_seen[why] = 1'b1;
    in_candidate = 1'b0;
  endfunction

  function automatic void take_byte(input byte_item_t it);
    logic [7:0]  b;
    int unsigned at;
    b = it.data_byte;
    if (it.start_req) begin
      open_candidate(1'b1);
    end else if (!in_candidate) begin
      return;
    end
    bytes_used++;
    at = next_offset;
    byte_sum = byte_sum + b;
    next_offset++;
    if (at < SIG_LEN) begin
      if (b != SIG_BYTES[at]) sig_ok = 1'b0;
      if (!sig_ok) post_verdict(1'b0, REASON_SIGNATURE);
      return;
    end
    if (at == REV_OFFSET) rev_byte = b;
    if (at == V1_LAST) begin
      if (byte_sum != 8'd0) post_verdict(1'b0, REASON_CHECKSUM);
      else if (rev_byte < EXT_REVISION) post_verdict(1'b1, REASON_OK);
    end else if (at >= LEN_FIRST && at <= LEN_LAST) begin
      // length field is little endian
      decl_len = decl_len | (32'(b) << ((at - LEN_FIRST) * 8));
      if (at == LEN_LAST) begin
        if (decl_len < V2_LEN) post_verdict(1'b0, REASON_LEN_SHORT);
        else if (decl_len > MAX_BYTES) post_verdict(1'b0, REASON_LEN_OVER);
      end
    end else if (at > LEN_LAST && 32'(at + 1) == decl_len) begin
      if (byte_sum != 8'd0) post_verdict(1'b0, REASON_EXT_CSUM);
      else post_verdict(1'b1, REASON_OK);
    end
  endfunction

  always @(posedge clk) begin : watch
    verdict_item_t want;
    if (rst) begin
      open_candidate(1'b0);
      verdict_q.delete();
    end else begin
      if (byte_valid && !byte_stall) take_byte(byte_item);
      if (verdict_valid && !verdict_stall) begin
        if (verdict_q.size() == 0) begin
          fail_count++;
          $display("%0t: verdict with none expected: valid_res=%0b reason=%0d revision=%02h",
                   $time, verdict_item.valid_res, verdict_item.reason, verdict_item.revision);
        end else begin
          want = verdict_q.pop_front();
          if (verdict_item.valid_res !== want.valid_res) begin
            fail_count++;
            $display("%0t: valid_res expected %0b actual %0b",
                     $time, want.valid_res, verdict_item.valid_res);
          end
          if (verdict_item.reason !== want.reason) begin
            fail_count++;
            $display("%0t: reason expected %0d actual %0d",
                     $time, want.reason, verdict_item.reason);
          end
          if (verdict_item.revision !== want.revision) begin
            fail_count++;
            $display("%0t: revision expected %02h actual %02h",
                     $time, want.revision, verdict_item.revision);
          end
        end
      end
    end
    outstanding <= verdict_q.size();
  end

endmodule

### test/tb_rsdp_descriptor_validator_unit.sv
`timescale 1ns / 1ps
// tb_rsdp_descriptor_validator_unit: drives descriptor bytes into the validator and
// randomizes receiver stalls; depends on rdv_pkg, rdv_verdict_checker and the unit
module tb_rsdp_descriptor_validator_unit;
  import rdv_pkg::*;

  localparam int unsigned MAX_BYTES = RDV_MAX_BYTES_DEFAULT;
  localparam int          BYTE_GOAL = 1050;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          byte_valid = 1'b0;
  logic          byte_stall;
  byte_item_t    byte_item = '0;
  logic          verdict_valid;
  logic          verdict_stall = 1'b0;
  verdict_item_t verdict_item;

  int            fail_count;
  int            outstanding;
  int            bytes_used;
  int            verdicts_due;
  logic [5:0]    reasons_seen;

  int            phase = 0;
  int            tx_idle_pct = 9;
  int            rx_stall_pct = 56;
  logic          hold_done = 1'b0;
  int            hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rsdp_descriptor_validator_unit #(.MAX_DESCRIPTOR_BYTES(MAX_BYTES)) dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_item     (byte_item),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_item  (verdict_item)
  );

  rdv_verdict_checker #(.MAX_BYTES(MAX_BYTES)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_item     (byte_item),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_item  (verdict_item),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .bytes_used    (bytes_used),
    .verdicts_due  (verdicts_due),
    .reasons_seen  (reasons_seen)
  );

  // receiver: random stalls, plus one long hold-off when the last phase begins
  always @(posedge clk) begin
    if (phase == 2 && !hold_done) begin
      hold_done     <= 1'b1;
      hold_left     <= 400;
      verdict_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      verdict_stall <= 1'b1;
    end else begin
      verdict_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic first);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= '{data_byte: data, start_req: first};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // one candidate with correct signature and sums, optionally damaged or cut short
  task automatic send_candidate(input logic [7:0] rev, input logic [31:0] decl,
                                input bit mangle);
    logic [7:0] img [MAX_BYTES];
    logic [7:0] acc;
    int         n;
    int         i;
    for (i = 0; i < MAX_BYTES; i++) img[i] = 8'($urandom);
    for (i = 0; i < SIG_LEN; i++) img[i] = SIG_BYTES[i];
    img[REV_OFFSET] = rev;
    for (i = 0; i < 4; i++) img[LEN_FIRST + i] = decl[8*i +: 8];
    if (rev < EXT_REVISION) n = V1_LAST + 1;
    else if (decl >= V2_LEN && decl <= MAX_BYTES) n = decl;
    else n = LEN_LAST + 1;
    // checksum byte at offset 8 zeroes the sum over the first 20 bytes
    acc = 8'd0;
    for (i = 0; i <= V1_LAST; i++) if (i != 8) acc = acc + img[i];
    img[8] = -acc;
    // extended checksum byte at offset 32 zeroes the sum over the whole length
    acc = 8'd0;
    for (i = 0; i < MAX_BYTES; i++) if (i != 32 && i < decl) acc = acc + img[i];
    img[32] = -acc;
    if (mangle) begin
      if ($urandom_range(0, 99) < 60) begin
        i = $urandom_range(0, n - 1);
        img[i] = img[i] ^ 8'($urandom_range(1, 255));
      end
      if ($urandom_range(0, 99) < 30) n = $urandom_range(1, n - 1);
    end
    for (i = 0; i < n; i++) send_byte(img[i], i == 0);
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin : stimulus
    int          k;
    logic [7:0]  rev;
    logic [31:0] decl;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // bytes with no open candidate are dropped
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // restart in mid candidate, then a signature miss on the first byte
    send_byte(SIG_BYTES[0], 1'b1);
    send_byte(8'hFF, 1'b1);
    // largest declared length is over the limit
    send_candidate(EXT_REVISION, 32'hFFFF_FFFF, 1'b0);

    while (bytes_used < BYTE_GOAL) begin
      if (bytes_used >= 2 * BYTE_GOAL / 3) begin
        phase        = 2;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end else if (bytes_used >= BYTE_GOAL / 3) begin
        phase        = 1;
        tx_idle_pct  = 56;
        rx_stall_pct = 9;
      end
      if ($urandom_range(0, 99) < 10) begin
        // noise: stray bytes, some flagged as a start
        repeat ($urandom_range(1, 3))
          send_byte(8'($urandom), $urandom_range(0, 99) < 30);
      end else begin
        k = $urandom_range(0, 99);
        if (k < 25) rev = 8'($urandom_range(0, 1));
        else if (k < 35) rev = EXT_REVISION;
        else rev = 8'($urandom_range(2, 255));
        k = $urandom_range(0, 99);
        if (k < 6) decl = $urandom_range(0, V2_LEN - 1);
        else if (k < 8) decl = 32'd0;
        else if (k < 10) decl = V2_LEN - 1;
        else if (k < 14) decl = V2_LEN;
        else if (k < 18) decl = MAX_BYTES;
        else if (k < 20) decl = MAX_BYTES + 1;
        else if (k < 24) decl = $urandom;
        else if (k < 26) decl = 32'hFFFF_FFFF;
        else decl = $urandom_range(V2_LEN, V2_LEN + 8);
        send_candidate(rev, decl, $urandom_range(0, 99) < 30);
      end
    end
    byte_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d candidate bytes and %0d verdicts; reason codes hit (bit per code): %b",
             bytes_used, verdicts_due, reasons_seen);
    $display("three stall mixes plus one long receiver hold-off with the input backed up");
    if (fail_count == 0) begin
      $display("PASS rsdp_descriptor_validator_unit");
    end else begin
      $display("FAIL rsdp_descriptor_validator_unit");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout: %0d verdicts still outstanding", outstanding);
    $display("FAIL rsdp_descriptor_validator_unit");
    $finish;
  end

endmodule
